// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
    `ASSERT_CLK(lbl, !(cond), msg)

`endif

// ===== rtl/ppfma_pkg.sv =====
// shared types and constants for the power profile alignment block
package ppfma_pkg;

    localparam int SAMPLE_W        = 20;
    localparam int TDATA_W         = 24;
    localparam int CFG_IDX_W       = 2;
    localparam int MAX_SAMPLES_DEF = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MEAN  = 2'd0,
        CFG_FLOOR = 2'd1,
        CFG_PEAK  = 2'd2
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_LOAD,
        S_PREP,
        S_SUM,
        S_SUM_END,
        S_DIVI,
        S_DIV,
        S_MEAN,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

    typedef struct packed {
        logic load;      // input side open
        logic prep;      // latch peak shift, clear sum and index
        logic sum_rd;    // read next stored sample for the sum pass
        logic div_init;  // load divider with |sum|
        logic div_step;  // one quotient bit
        logic mean;      // latch mean shift, clear index
        logic emit_ld;   // load output register, advance index
        logic clear;     // end of block: clear count, peak, overflow
    } t_cmd;

    typedef struct packed {
        logic last_idx;  // index points at the last stored sample
        logic div_done;  // divider on its final step
        logic obuf_free; // output register can take a new result
    } t_status;

endpackage

// ===== rtl/ppfma_ctrl.sv =====
// controller state machine sequencing load, sum, divide and emit phases
`include "assert_macros.svh"

module ppfma_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    input  ppfma_pkg::t_status i_status,
    output ppfma_pkg::t_cmd   o_cmd
);
    import ppfma_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (i_in_valid && i_in_last) begin
                    n_state = S_PREP;
                end
            end
            S_PREP:    n_state = S_SUM;
            S_SUM: begin
                if (i_status.last_idx) begin
                    n_state = S_SUM_END;
                end
            end
            S_SUM_END: n_state = S_DIVI;
            S_DIVI:    n_state = S_DIV;
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_MEAN;
                end
            end
            S_MEAN:    n_state = S_EMIT_RD;
            S_EMIT_RD: n_state = S_EMIT_LD;
            S_EMIT_LD: begin
                if (i_status.obuf_free) begin
                    n_state = i_status.last_idx ? S_LOAD : S_EMIT_RD;
                end
            end
            default:   n_state = S_LOAD;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_LOAD:    o_cmd.load     = 1'b1;
            S_PREP:    o_cmd.prep     = 1'b1;
            S_SUM:     o_cmd.sum_rd   = 1'b1;
            S_SUM_END: o_cmd          = '0;
            S_DIVI:    o_cmd.div_init = 1'b1;
            S_DIV:     o_cmd.div_step = 1'b1;
            S_MEAN:    o_cmd.mean     = 1'b1;
            S_EMIT_RD: o_cmd          = '0;
            S_EMIT_LD: begin
                o_cmd.emit_ld = i_status.obuf_free;
                o_cmd.clear   = i_status.obuf_free && i_status.last_idx;
            end
            default:   o_cmd          = '0;
        endcase
    end

    `ASSERT_CLK(a_prep_from_load, (r_state == S_PREP) |-> ($past(r_state) == S_LOAD), "prep not entered from load")
    `ASSERT_CLK(a_block_end_load, o_cmd.clear |=> (r_state == S_LOAD), "block end did not return to load")
    `ASSERT_CLK(a_mean_to_emit, (r_state == S_MEAN) |=> (r_state == S_EMIT_RD), "mean not followed by emit")

endmodule

// ===== rtl/ppfma_dp.sv =====
// datapath: sample memory, peak tracking, clip-sum, serial divider, output register
`include "assert_macros.svh"

module ppfma_dp #(
    parameter int MAX_SAMPLES = ppfma_pkg::MAX_SAMPLES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ppfma_pkg::t_cmd                      i_cmd,
    output ppfma_pkg::t_status                   o_status,
    input  logic                                 i_in_valid,
    input  logic signed [ppfma_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                 i_cfg_valid,
    input  logic [ppfma_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic signed [ppfma_pkg::SAMPLE_W-1:0] i_cfg_data,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic signed [ppfma_pkg::SAMPLE_W-1:0] o_out_sample,
    output logic                                 o_out_last,
    output logic                                 o_out_trunc
);
    import ppfma_pkg::*;

    localparam int CW    = $clog2(MAX_SAMPLES + 1);
    localparam int AW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int T_W   = SAMPLE_W + 2;
    localparam int SUM_W = T_W + $clog2(MAX_SAMPLES);
    localparam int DCW   = $clog2(SUM_W);
    localparam int R_W   = T_W + 2;
    localparam logic signed [R_W-1:0] SAT_HI = R_W'((2 ** (SAMPLE_W - 1)) - 1);
    localparam logic signed [R_W-1:0] SAT_LO = -SAT_HI - R_W'(1);
    localparam logic [CW-1:0]         CAP    = CW'(MAX_SAMPLES);

    // configuration registers
    logic signed [SAMPLE_W-1:0] r_cfg_mean;
    logic signed [SAMPLE_W-1:0] r_cfg_floor;
    logic signed [SAMPLE_W-1:0] r_cfg_peak;

    // block state
    logic [SAMPLE_W-1:0]        r_mem [MAX_SAMPLES];
    logic signed [SAMPLE_W-1:0] r_rdata;
    logic [CW-1:0]              r_count;
    logic signed [SAMPLE_W-1:0] r_peak;
    logic                       r_ovf;
    logic [AW-1:0]              r_idx;

    // arithmetic registers
    logic signed [SAMPLE_W:0]   r_shift0;
    logic signed [T_W:0]        r_shift1;
    logic signed [SUM_W-1:0]    r_sum;
    logic                       r_acc_en;
    logic [SUM_W-1:0]           r_quo;
    logic [CW:0]                r_rem;
    logic [DCW-1:0]             r_div_cnt;
    logic                       r_sum_neg;

    // output register
    logic                       r_ovalid;
    logic signed [SAMPLE_W-1:0] r_osample;
    logic                       r_olast;
    logic                       r_otrunc;

    logic                       load_acc;
    logic                       has_room;
    logic signed [T_W-1:0]      t_diff;
    logic signed [T_W-1:0]      t_clip;
    logic [CW:0]                rem_sh;
    logic                       rem_ge;
    logic [SUM_W-1:0]           sum_mag;
    logic signed [T_W-1:0]      mean_val;
    logic signed [R_W-1:0]      r_val;
    logic signed [SAMPLE_W-1:0] sat_val;

    assign load_acc = i_cmd.load && i_in_valid;
    assign has_room = (r_count < CAP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mean  <= '0;
            r_cfg_floor <= '0;
            r_cfg_peak  <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_MEAN:  r_cfg_mean  <= i_cfg_data;
                CFG_FLOOR: r_cfg_floor <= i_cfg_data;
                CFG_PEAK:  r_cfg_peak  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sample memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (load_acc && has_room) begin
            r_mem[r_count[AW-1:0]] <= i_sample;
        end
        r_rdata <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_peak  <= {1'b1, {(SAMPLE_W-1){1'b0}}};
            r_ovf   <= 1'b0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
            r_peak  <= {1'b1, {(SAMPLE_W-1){1'b0}}};
            r_ovf   <= 1'b0;
        end else if (load_acc) begin
            if (has_room) begin
                r_count <= r_count + CW'(1);
                if (i_sample > r_peak) begin
                    r_peak <= i_sample;
                end
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.prep || i_cmd.mean) begin
            r_idx <= '0;
        end else if (i_cmd.sum_rd || i_cmd.emit_ld) begin
            r_idx <= r_idx + AW'(1);
        end
    end

    // peak-aligned, floor-clipped value of the sample read last cycle
    assign t_diff = T_W'(r_rdata) - T_W'(r_shift0);
    assign t_clip = (t_diff < T_W'(r_cfg_floor)) ? T_W'(r_cfg_floor) : t_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_en <= 1'b0;
        end else begin
            r_acc_en <= i_cmd.sum_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_shift0 <= (SAMPLE_W+1)'(r_peak) - (SAMPLE_W+1)'(r_cfg_peak);
            r_sum    <= '0;
        end else if (r_acc_en) begin
            r_sum <= r_sum + SUM_W'(t_clip);
        end
    end

    // restoring divider, one quotient bit per cycle on |sum| / count
    assign sum_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign rem_sh  = {r_rem[CW-1:0], r_quo[SUM_W-1]};
    assign rem_ge  = (rem_sh >= {1'b0, r_count});

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_quo     <= sum_mag;
            r_rem     <= '0;
            r_div_cnt <= DCW'(SUM_W - 1);
            r_sum_neg <= r_sum[SUM_W-1];
        end else if (i_cmd.div_step) begin
            r_quo     <= {r_quo[SUM_W-2:0], rem_ge};
            r_rem     <= rem_ge ? (rem_sh - {1'b0, r_count}) : rem_sh;
            r_div_cnt <= r_div_cnt - DCW'(1);
        end
    end

    // quotient truncated toward zero, sign restored
    assign mean_val = r_sum_neg ? -T_W'(r_quo) : T_W'(r_quo);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mean) begin
            r_shift1 <= (T_W+1)'(mean_val) - (T_W+1)'(r_cfg_mean);
        end
    end

    assign r_val   = R_W'(t_clip) - R_W'(r_shift1);
    assign sat_val = (r_val > SAT_HI) ? SAMPLE_W'(SAT_HI) :
                     (r_val < SAT_LO) ? SAMPLE_W'(SAT_LO) : SAMPLE_W'(r_val);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit_ld) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_ld) begin
            r_osample <= sat_val;
            r_olast   <= o_status.last_idx;
            r_otrunc  <= r_ovf;
        end
    end

    assign o_status.last_idx  = (CW'(r_idx) == (r_count - CW'(1)));
    assign o_status.div_done  = (r_div_cnt == '0);
    assign o_status.obuf_free = !r_ovalid || i_out_ready;

    assign o_out_valid  = r_ovalid;
    assign o_out_sample = r_osample;
    assign o_out_last   = r_olast;
    assign o_out_trunc  = r_otrunc;

    `ASSERT_NEVER(a_count_bound, r_count > CAP, "sample count beyond capacity")
    `ASSERT_CLK(a_clear_block, i_cmd.clear |=> ((r_count == '0) && !r_ovf), "block state not cleared")
    `ASSERT_CLK(a_clip_floor, r_acc_en |-> (t_clip >= T_W'(r_cfg_floor)), "summed value below floor")

endmodule

// ===== rtl/power_profile_peak_floor_mean_align.sv =====
// top level: peak, floor and mean alignment of a block of power samples
//
//  channel    | dir | handshake              | payload
//  -----------+-----+------------------------+------------------------------------------
//  s_axis     | in  | tvalid / tready        | tdata[19:0] sim_sample, tlast sample_last
//  m_axis     | out | tvalid / tready        | tdata[19:0] aligned_sample, tlast
//             |     |                        | result_last, tuser block_truncated
//  cfg        | in  | valid / ready (always) | index 0 mean, 1 floor, 2 peak; data Q12.8
//
//  loading takes one cycle per sample; tready is high only while the block is loading
//  after the last sample: a setup step, a clip-and-sum pass over the memory,
//  the bit-serial restoring divider on |sum| / count, then the mean shift
//  each result then takes a memory read and an output register load, and waits while m_axis stalls
//  i_rst_n is synchronous active low; config goes back to 0 and the block to empty
//  the memory is not cleared: only entries below the sample count are ever read

module power_profile_peak_floor_mean_align #(
    parameter int MAX_SAMPLES = ppfma_pkg::MAX_SAMPLES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input samples
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [ppfma_pkg::TDATA_W-1:0]    i_s_axis_tdata,  // [19:0] sim_sample, [23:20] zero
    input  logic                             i_s_axis_tlast,
    // aligned results
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [ppfma_pkg::TDATA_W-1:0]    o_m_axis_tdata,  // [19:0] aligned_sample, [23:20] zero
    output logic                             o_m_axis_tlast,
    output logic                             o_m_axis_tuser,  // [0] block_truncated
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ppfma_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ppfma_pkg::SAMPLE_W-1:0]   i_cfg_data
);
    import ppfma_pkg::*;

    t_cmd                       cmd;
    t_status                    status;
    logic signed [SAMPLE_W-1:0] out_sample;

    // registers take every write transfer at once
    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = cmd.load;

    ppfma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_last  (i_s_axis_tlast),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ppfma_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_in_valid   (i_s_axis_tvalid),
        .i_sample     (i_s_axis_tdata[SAMPLE_W-1:0]),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_out_sample (out_sample),
        .o_out_last   (o_m_axis_tlast),
        .o_out_trunc  (o_m_axis_tuser)
    );

    // pad the result to whole bytes
    assign o_m_axis_tdata = {{(TDATA_W-SAMPLE_W){1'b0}}, out_sample};

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for the power profile peak, floor and mean alignment block
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ppfma_pkg::*;

    // no transfer of any kind for this many cycles means the block hung
    localparam int IDLE_LIMIT    = 4000;
    // long receiver hold-off so the block backs up and drops its input tready
    localparam int HOLD_CYCLES   = 400;
    // margin after the last result of a block before registers are touched
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 40;
    // unmapped register index, the block must ignore writes to it
    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;
    localparam longint SAMPLE_MIN = -524288;
    localparam longint SAMPLE_MAX = 524287;

    typedef logic signed [SAMPLE_W-1:0] t_q12_8;

    typedef struct packed {
        t_q12_8 sample;
        logic   last;
    } t_power_in;

    typedef struct packed {
        t_q12_8 aligned;
        logic   last;
        logic   truncated;
    } t_power_out;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [TDATA_W-1:0]   i_s_axis_tdata  = '0;    // [19:0] sim_sample, [23:20] zero
    logic                 i_s_axis_tlast  = 1'b0;  // sample_last
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   o_m_axis_tdata;          // [19:0] aligned_sample, [23:20] zero
    logic                 o_m_axis_tlast;          // result_last
    logic                 o_m_axis_tuser;          // [0] block_truncated
    logic                 i_cfg_valid     = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index     = '0;
    logic [SAMPLE_W-1:0]  i_cfg_data      = '0;

    power_profile_peak_floor_mean_align u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // stimulus and expectation stores
    t_power_in  power_pending[$];
    t_power_out aligned_expected[$];
    t_power_in  next_in;
    logic       s_taken = 1'b0;
    int         snd_idle_pct = 0;
    int         rcv_idle_pct = 0;
    bit         hold_armed   = 1'b0;
    bit         hold_done    = 1'b0;
    int         hold_left    = 0;
    int         mismatch_cnt = 0;
    int         idle_cycles  = 0;

    // block model: levels, stored samples, running peak and drop flag
    longint lvl_mean, lvl_floor, lvl_peak;
    longint blk_store[MAX_SAMPLES_DEF];
    int     blk_count;
    longint blk_peak;
    bit     blk_dropped;

    function automatic void clear_power_block();
        blk_count   = 0;
        blk_peak    = SAMPLE_MIN;
        blk_dropped = 1'b0;
    endfunction

    // absorb one accepted sample; a last sample turns the block into aligned results
    function automatic void load_power_sample(t_q12_8 smp, logic is_last);
        longint     peak_shift, mean_shift, total, avg, v;
        int         n;
        t_power_out r;
        if (blk_count < MAX_SAMPLES_DEF) begin
            blk_store[blk_count] = smp;
            blk_count++;
            if (smp > blk_peak)
                blk_peak = smp;
        end else begin
            // store full: sample dropped, peak untouched
            blk_dropped = 1'b1;
        end
        if (!is_last)
            return;
        n = blk_count;
        if (n != 0) begin
            // move the peak onto the target, raise anything under the floor
            peak_shift = blk_peak - lvl_peak;
            total = 0;
            for (int i = 0; i < n; i++) begin
                v = blk_store[i] - peak_shift;
                if (v < lvl_floor)
                    v = lvl_floor;
                blk_store[i] = v;
                total += v;
            end
            // longint division truncates toward zero
            avg = total / n;
            mean_shift = avg - lvl_mean;
            for (int i = 0; i < n; i++) begin
                v = blk_store[i] - mean_shift;
                if (v > SAMPLE_MAX)
                    v = SAMPLE_MAX;
                if (v < SAMPLE_MIN)
                    v = SAMPLE_MIN;
                r.aligned   = t_q12_8'(v);
                r.last      = (i == n - 1);
                r.truncated = blk_dropped;
                aligned_expected = {aligned_expected, r};
            end
        end
        clear_power_block();
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
        mismatch_cnt++;
    endtask

    task automatic check_aligned();
        t_power_out want;
        if (aligned_expected.size() == 0) begin
            report_mismatch("result with nothing pending", o_m_axis_tdata, 0);
            return;
        end
        want = aligned_expected.pop_front();
        if (o_m_axis_tdata !== {{(TDATA_W-SAMPLE_W){1'b0}}, want.aligned})
            report_mismatch("aligned_sample", o_m_axis_tdata, want.aligned & 20'hFFFFF);
        if (o_m_axis_tlast !== want.last)
            report_mismatch("result_last", o_m_axis_tlast, want.last);
        if (o_m_axis_tuser !== want.truncated)
            report_mismatch("block_truncated", o_m_axis_tuser, want.truncated);
    endtask

    // monitor: register writes, sample transfers and result transfers at the rising edge
    always @(posedge i_clk) begin
        s_taken <= i_s_axis_tvalid && o_s_axis_tready;
        if (!i_rst_n) begin
            lvl_mean  = 0;
            lvl_floor = 0;
            lvl_peak  = 0;
            clear_power_block();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MEAN:  lvl_mean  = longint'($signed(i_cfg_data));
                    CFG_FLOOR: lvl_floor = longint'($signed(i_cfg_data));
                    CFG_PEAK:  lvl_peak  = longint'($signed(i_cfg_data));
                    default: ; // unmapped index, nothing changes
                endcase
            end
            if (i_s_axis_tvalid && o_s_axis_tready)
                load_power_sample(t_q12_8'(i_s_axis_tdata[SAMPLE_W-1:0]), i_s_axis_tlast);
            if (o_m_axis_tvalid && i_m_axis_tready)
                check_aligned();
        end
    end

    // sample driver: holds an offer until its transfer, otherwise pulls from the pending queue
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (i_s_axis_tvalid && !s_taken) begin
            // offer stays up unchanged
        end else if (power_pending.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
            next_in = power_pending.pop_front();
            i_s_axis_tvalid <= 1'b1;
            i_s_axis_tdata  <= {{(TDATA_W-SAMPLE_W){1'b0}}, next_in.sample};
            i_s_axis_tlast  <= next_in.last;
        end else begin
            i_s_axis_tvalid <= 1'b0;
        end
    end

    // result receiver: random stalls, plus one long hold-off once armed
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            i_m_axis_tready <= 1'b0;
            hold_left       <= hold_left - 1;
        end else if (hold_armed && !hold_done && aligned_expected.size() != 0) begin
            i_m_axis_tready <= 1'b0;
            hold_left       <= HOLD_CYCLES;
            hold_done       <= 1'b1;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_in(t_q12_8 smp, logic is_last);
        t_power_in it;
        it.sample = smp;
        it.last   = is_last;
        power_pending = {power_pending, it};
    endtask

    // one block of n samples: either a tight dB profile or raw full-range values
    task automatic queue_block(int n);
        bit wide;
        int base;
        wide = ($urandom_range(3) == 0);
        base = int'($urandom_range(0, 40960)) - 30720;
        for (int i = 0; i < n; i++) begin
            if (wide)
                push_in(t_q12_8'($urandom), i == n - 1);
            else
                push_in(t_q12_8'(base + int'($urandom_range(0, 12800)) - 6400), i == n - 1);
        end
    endtask

    // block idle: nothing queued, nothing offered, no result outstanding
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (power_pending.size() != 0 || i_s_axis_tvalid || aligned_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, t_q12_8 val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic cfg_levels(t_q12_8 mean_lvl, t_q12_8 floor_lvl, t_q12_8 peak_lvl);
        cfg_write(CFG_MEAN, mean_lvl);
        cfg_write(CFG_FLOOR, floor_lvl);
        cfg_write(CFG_PEAK, peak_lvl);
    endtask

    // extremes, raw random levels, or a plausible measured dB level
    function automatic t_q12_8 pick_level();
        case ($urandom_range(3))
            0:       pick_level = $urandom_range(1) ? t_q12_8'(SAMPLE_MAX) : t_q12_8'(SAMPLE_MIN);
            1:       pick_level = t_q12_8'($urandom);
            default: pick_level = t_q12_8'(int'($urandom_range(0, 40960)) - 30720);
        endcase
    endfunction

    // random phase: fresh levels, an optional big block, then small blocks
    task automatic random_phase(int snd_pct, int rcv_pct, bit pressure, int big, int small_items);
        int queued;
        int n;
        wait_idle();
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        hold_armed   = pressure;
        cfg_levels(pick_level(), pick_level(), pick_level());
        if (big != 0)
            queue_block(big);
        queued = 0;
        while (queued < small_items) begin
            n = $urandom_range(1, 8);
            queue_block(n);
            queued += n;
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        snd_idle_pct = 19;
        rcv_idle_pct = 66;

        // lone most-negative sample with all levels at their reset value
        push_in(t_q12_8'(SAMPLE_MIN), 1'b1);

        // typical levels, sample extremes and small values around zero
        wait_idle();
        cfg_levels(-10240, -20480, -2560);
        push_in(t_q12_8'(SAMPLE_MAX), 1'b0);
        push_in(t_q12_8'(SAMPLE_MIN), 1'b0);
        push_in(0, 1'b0);
        push_in(1, 1'b0);
        push_in(-1, 1'b0);
        push_in(12800, 1'b0);
        push_in(-25600, 1'b0);
        push_in(256, 1'b1);

        // wide intermediates and floor clipping, outputs saturate high
        wait_idle();
        cfg_levels(t_q12_8'(SAMPLE_MAX), t_q12_8'(SAMPLE_MIN), 0);
        push_in(200000, 1'b0);
        push_in(-300000, 1'b0);
        push_in(100000, 1'b0);
        push_in(t_q12_8'(SAMPLE_MIN), 1'b1);

        // negative fractional mean truncates toward zero, outputs saturate low
        wait_idle();
        cfg_levels(t_q12_8'(SAMPLE_MIN), t_q12_8'(SAMPLE_MIN), t_q12_8'(SAMPLE_MAX));
        push_in(t_q12_8'(SAMPLE_MIN), 1'b0);
        push_in(t_q12_8'(SAMPLE_MAX), 1'b0);
        push_in(0, 1'b0);
        push_in(-1, 1'b1);

        // floor above the aligned peak: every sample clipped
        wait_idle();
        cfg_levels(123, t_q12_8'(SAMPLE_MAX), t_q12_8'(SAMPLE_MIN));
        push_in(-5000, 1'b0);
        push_in(7000, 1'b0);
        push_in(t_q12_8'(SAMPLE_MIN), 1'b1);

        // write to the unmapped index must leave all levels alone
        wait_idle();
        cfg_write(CFG_NONE, t_q12_8'($urandom));
        push_in(-3000, 1'b0);
        push_in(4000, 1'b1);

        // random blocks: sender idles a little, receiver a lot
        random_phase(19, 66, 1'b0, 0, 10);
        random_phase(19, 66, 1'b0, 0, 8);
        // roles swapped
        random_phase(66, 19, 1'b0, 0, 10);
        // no idling, a block that fills the store and drops its tail, and a long hold-off
        random_phase(0, 0, 1'b1, MAX_SAMPLES_DEF + int'($urandom_range(1, 3)), 6);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && aligned_expected.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
